>>> design/assert_macros.svh
// Assertion macros for the design files; the sequencer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/bdb_pkg.sv
// Shared constants, types and helpers for the digits-to-bytes converter.
package bdb_pkg;

	localparam int DIGIT_BITS = 30;
	localparam int MAX_BYTES  = 32;
	localparam int ACC_W      = 38;
	localparam int CNT_W      = 6;
	localparam int POS_W      = 5;
	localparam int ST_W       = 2;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	// status codes
	localparam logic [ST_W-1:0] ST_OK           = 2'd0;
	localparam logic [ST_W-1:0] ST_NEG_UNSIGNED = 2'd1;
	localparam logic [ST_W-1:0] ST_TOO_BIG      = 2'd2;

	// register indexes
	localparam logic [1:0] REG_BYTE_COUNT  = 2'd0;
	localparam logic [1:0] REG_LSB_FIRST   = 2'd1;
	localparam logic [1:0] REG_SIGNED_MODE = 2'd2;

	// datapath operations
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_COMP  = 3'd2;
	localparam logic [2:0] OP_MERGE = 3'd3;
	localparam logic [2:0] OP_BYTE  = 3'd4;
	localparam logic [2:0] OP_TAIL  = 3'd5;
	localparam logic [2:0] OP_FILL  = 3'd6;

	typedef struct packed {
		logic [CNT_W-1:0] byte_count;
		logic             lsb_first;
		logic             signed_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0]            op;
		logic                  start;
		logic [DIGIT_BITS-1:0] digit;
		logic                  neg;
		logic                  last;
	} dp_cmd_t;

	typedef struct packed {
		logic bits_ge8;
		logic bits_zero;
		logic room;
		logic full_exact;
		logic top_mismatch;
		logic last;
	} dp_stat_t;

	typedef struct packed {
		logic            load;
		logic            byte_valid;
		logic [ST_W-1:0] status;
		logic            done;
	} emit_t;

	// number of significant bits
	function automatic logic [CNT_W-1:0] bit_len(input logic [DIGIT_BITS-1:0] v);
		logic [CNT_W-1:0] len;
		len = '0;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			if (v[i]) begin
				len = CNT_W'(i + 1);
			end
		end
		return len;
	endfunction

endpackage

>>> design/bignum_digits_to_bytes_core.sv
// Converts sign-magnitude big-integer digits into two's complement or unsigned
// buffer bytes, one byte per cycle while the output is not stalled, through a
// single shared extraction unit. An accepted digit holds item_stall high while
// it is worked: a complement step and a merge step into the bit accumulator,
// one step per byte formed (up to four bytes for a 30-bit digit), then a step
// to leave the byte loop. The last digit adds a tail step for the leftover byte
// (taken even when there is none), one step per sign-fill byte up to the buffer
// length, a step to leave the fill loop and a closing status result. Byte and
// status transactions leave through one output register, and a stall there
// holds the byte loop. Digits of a number that has already failed are absorbed
// while the sequencer stays idle.
module bignum_digits_to_bytes_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bdb_pkg::ADDR_W-1:0]     paddr,
	input  logic [bdb_pkg::DATA_W-1:0]     pwdata,
	output logic [bdb_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [bdb_pkg::DIGIT_BITS-1:0] digit_value,
	input  logic                           is_negative,
	input  logic                           last_digit,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [7:0]                     byte_value,
	output logic [bdb_pkg::POS_W-1:0]      byte_position,
	output logic                           byte_valid,
	output logic [bdb_pkg::ST_W-1:0]       status,
	output logic                           conversion_done
);

	bdb_pkg::cfg_t             cfg;
	bdb_pkg::dp_cmd_t          cmd;
	bdb_pkg::dp_stat_t         stat;
	bdb_pkg::emit_t            emit;
	logic [7:0]                byte_value_c;
	logic [bdb_pkg::POS_W-1:0] byte_pos_c;
	logic                      out_free;

	logic                      result_valid_q;
	logic [7:0]                byte_value_q;
	logic [bdb_pkg::POS_W-1:0] byte_position_q;
	logic                      byte_valid_q;
	logic [bdb_pkg::ST_W-1:0]  status_q;
	logic                      done_q;

	bdb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdb_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.digit_value (digit_value),
		.is_negative (is_negative),
		.last_digit  (last_digit),
		.out_free    (out_free),
		.stat        (stat),
		.cmd         (cmd),
		.emit        (emit)
	);

	bdb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.byte_value_c (byte_value_c),
		.byte_pos_c   (byte_pos_c)
	);

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit.load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			byte_value_q    <= emit.byte_valid ? byte_value_c : 8'h00;
			byte_position_q <= emit.byte_valid ? byte_pos_c : '0;
			byte_valid_q    <= emit.byte_valid;
			status_q        <= emit.status;
			done_q          <= emit.done;
		end
	end

	assign result_valid    = result_valid_q;
	assign byte_value      = byte_value_q;
	assign byte_position   = byte_position_q;
	assign byte_valid      = byte_valid_q;
	assign status          = status_q;
	assign conversion_done = done_q;

endmodule

>>> design/bdb_cfg.sv
// APB register block: buffer length, byte order and signedness.
module bdb_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bdb_pkg::ADDR_W-1:0]  paddr,
	input  logic [bdb_pkg::DATA_W-1:0]  pwdata,
	output logic [bdb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output bdb_pkg::cfg_t               cfg
);

	logic [bdb_pkg::CNT_W-1:0] byte_count_q;
	logic                      lsb_first_q;
	logic                      signed_mode_q;
	logic                      wr_en;
	logic [1:0]                reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= bdb_pkg::CNT_W'(8);
			lsb_first_q   <= 1'b1;
			signed_mode_q <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				bdb_pkg::REG_BYTE_COUNT:  byte_count_q  <= pwdata[bdb_pkg::CNT_W-1:0];
				bdb_pkg::REG_LSB_FIRST:   lsb_first_q   <= pwdata[0];
				bdb_pkg::REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			bdb_pkg::REG_BYTE_COUNT:  prdata = bdb_pkg::DATA_W'(byte_count_q);
			bdb_pkg::REG_LSB_FIRST:   prdata = bdb_pkg::DATA_W'(lsb_first_q);
			bdb_pkg::REG_SIGNED_MODE: prdata = bdb_pkg::DATA_W'(signed_mode_q);
			default:                  prdata = '0;
		endcase
	end

	assign cfg.byte_count  = byte_count_q;
	assign cfg.lsb_first   = lsb_first_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

>>> design/bdb_dp.sv
// Datapath: complement adder, bit accumulator and byte extraction unit.
module bdb_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bdb_pkg::cfg_t               cfg,
	input  bdb_pkg::dp_cmd_t            cmd,
	output bdb_pkg::dp_stat_t           stat,
	output logic [7:0]                  byte_value_c,
	output logic [bdb_pkg::POS_W-1:0]   byte_pos_c
);

	logic [bdb_pkg::DIGIT_BITS-1:0] digit_q;
	logic                           neg_q;
	logic                           last_q;
	logic [bdb_pkg::DIGIT_BITS-1:0] t_q;
	logic                           neg_eff_q;
	logic [bdb_pkg::ACC_W-1:0]      acc_q;
	logic [bdb_pkg::CNT_W-1:0]      nbits_q;
	logic                           carry_q;
	logic [bdb_pkg::CNT_W-1:0]      written_q;
	logic                           top_q;

	logic [bdb_pkg::CNT_W-1:0]      n_eff;
	logic [bdb_pkg::DIGIT_BITS:0]   sum;
	logic [bdb_pkg::CNT_W-1:0]      add_bits;
	logic [bdb_pkg::CNT_W-1:0]      pos_be;

	assign n_eff = (cfg.byte_count > bdb_pkg::CNT_W'(bdb_pkg::MAX_BYTES)) ?
		bdb_pkg::CNT_W'(bdb_pkg::MAX_BYTES) : cfg.byte_count;

	// ones' complement plus running carry
	assign sum = {1'b0, ~digit_q} + {{bdb_pkg::DIGIT_BITS{1'b0}}, carry_q};

	// top digit only counts its significant bits (sign-aware)
	assign add_bits = last_q ? bdb_pkg::bit_len(neg_eff_q ? ~t_q : t_q) :
		bdb_pkg::CNT_W'(bdb_pkg::DIGIT_BITS);

	assign pos_be = n_eff - bdb_pkg::CNT_W'(1) - written_q;

	always_comb begin
		case (cmd.op)
			bdb_pkg::OP_BYTE: byte_value_c = acc_q[7:0];
			bdb_pkg::OP_TAIL: byte_value_c = acc_q[7:0] |
				(neg_eff_q ? (8'hff << nbits_q[2:0]) : 8'h00);
			bdb_pkg::OP_FILL: byte_value_c = neg_eff_q ? 8'hff : 8'h00;
			default:          byte_value_c = 8'h00;
		endcase
	end

	assign byte_pos_c = cfg.lsb_first ? written_q[bdb_pkg::POS_W-1:0] :
		pos_be[bdb_pkg::POS_W-1:0];

	// item fields and shift data
	always_ff @(posedge clk) begin
		case (cmd.op)
			bdb_pkg::OP_LOAD: begin
				digit_q <= cmd.digit;
				if (cmd.start) begin
					acc_q <= '0;
				end
			end
			bdb_pkg::OP_COMP: begin
				t_q <= neg_q ? sum[bdb_pkg::DIGIT_BITS-1:0] : digit_q;
			end
			bdb_pkg::OP_MERGE: begin
				acc_q <= acc_q | (bdb_pkg::ACC_W'(t_q) << nbits_q[2:0]);
			end
			bdb_pkg::OP_BYTE: begin
				acc_q <= acc_q >> 8;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q     <= 1'b0;
			last_q    <= 1'b0;
			neg_eff_q <= 1'b0;
			nbits_q   <= '0;
			carry_q   <= 1'b0;
			written_q <= '0;
			top_q     <= 1'b0;
		end else begin
			case (cmd.op)
				bdb_pkg::OP_LOAD: begin
					neg_q  <= cmd.neg;
					last_q <= cmd.last;
					if (cmd.start) begin
						nbits_q   <= '0;
						carry_q   <= cmd.neg;
						written_q <= '0;
						top_q     <= 1'b0;
					end
				end
				bdb_pkg::OP_COMP: begin
					if (neg_q) begin
						carry_q   <= sum[bdb_pkg::DIGIT_BITS];
						neg_eff_q <= !(last_q && sum[bdb_pkg::DIGIT_BITS]);
					end else begin
						neg_eff_q <= 1'b0;
					end
				end
				bdb_pkg::OP_MERGE: begin
					nbits_q <= nbits_q + add_bits;
				end
				bdb_pkg::OP_BYTE: begin
					nbits_q   <= nbits_q - bdb_pkg::CNT_W'(8);
					written_q <= written_q + bdb_pkg::CNT_W'(1);
					top_q     <= byte_value_c[7];
				end
				bdb_pkg::OP_TAIL, bdb_pkg::OP_FILL: begin
					written_q <= written_q + bdb_pkg::CNT_W'(1);
					top_q     <= byte_value_c[7];
				end
				default: ;
			endcase
		end
	end

	assign stat.bits_ge8     = nbits_q >= bdb_pkg::CNT_W'(8);
	assign stat.bits_zero    = nbits_q == '0;
	assign stat.room         = written_q < n_eff;
	assign stat.full_exact   = (written_q == n_eff) && (n_eff != '0);
	assign stat.top_mismatch = top_q != neg_eff_q;
	assign stat.last         = last_q;

endmodule

>>> design/bdb_seq.sv
// Sequencer: steps the datapath through one digit and raises results.
`include "assert_macros.svh"

module bdb_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bdb_pkg::cfg_t                  cfg,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [bdb_pkg::DIGIT_BITS-1:0] digit_value,
	input  logic                           is_negative,
	input  logic                           last_digit,
	input  logic                           out_free,
	input  bdb_pkg::dp_stat_t              stat,
	output bdb_pkg::dp_cmd_t               cmd,
	output bdb_pkg::emit_t                 emit
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COMP  = 3'd1;
	localparam logic [2:0] S_MERGE = 3'd2;
	localparam logic [2:0] S_EMIT  = 3'd3;
	localparam logic [2:0] S_TAIL  = 3'd4;
	localparam logic [2:0] S_FILL  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]                  state_q, state_n;
	logic                        inside_q, inside_n;
	logic                        discard_q, discard_n;
	logic [bdb_pkg::ST_W-1:0]    st_q, st_n;
	logic                        accept;

	assign item_stall = state_q != S_IDLE;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_n    = state_q;
		inside_n   = inside_q;
		discard_n  = discard_q;
		st_n       = st_q;
		cmd.op     = bdb_pkg::OP_NONE;
		cmd.start  = !inside_q;
		cmd.digit  = digit_value;
		cmd.neg    = is_negative;
		cmd.last   = last_digit;
		emit       = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (discard_q) begin
						// rest of a failed number is dropped
						if (last_digit) begin
							discard_n = 1'b0;
							inside_n  = 1'b0;
						end
					end else begin
						cmd.op   = bdb_pkg::OP_LOAD;
						inside_n = 1'b1;
						if (is_negative && !cfg.signed_mode) begin
							st_n    = bdb_pkg::ST_NEG_UNSIGNED;
							state_n = S_FIN;
						end else begin
							state_n = S_COMP;
						end
					end
				end
			end
			S_COMP: begin
				cmd.op  = bdb_pkg::OP_COMP;
				state_n = S_MERGE;
			end
			S_MERGE: begin
				cmd.op  = bdb_pkg::OP_MERGE;
				state_n = S_EMIT;
			end
			S_EMIT: begin
				if (stat.bits_ge8) begin
					if (!stat.room) begin
						st_n    = bdb_pkg::ST_TOO_BIG;
						state_n = S_FIN;
					end else if (out_free) begin
						cmd.op          = bdb_pkg::OP_BYTE;
						emit.load       = 1'b1;
						emit.byte_valid = 1'b1;
					end
				end else begin
					state_n = stat.last ? S_TAIL : S_IDLE;
				end
			end
			S_TAIL: begin
				if (!stat.bits_zero) begin
					if (!stat.room) begin
						st_n    = bdb_pkg::ST_TOO_BIG;
						state_n = S_FIN;
					end else if (out_free) begin
						cmd.op          = bdb_pkg::OP_TAIL;
						emit.load       = 1'b1;
						emit.byte_valid = 1'b1;
						state_n         = S_FILL;
					end
				end else if (stat.full_exact && cfg.signed_mode) begin
					// buffer filled exactly: top bit must agree with the sign
					st_n    = stat.top_mismatch ? bdb_pkg::ST_TOO_BIG : bdb_pkg::ST_OK;
					state_n = S_FIN;
				end else begin
					state_n = S_FILL;
				end
			end
			S_FILL: begin
				if (stat.room) begin
					if (out_free) begin
						cmd.op          = bdb_pkg::OP_FILL;
						emit.load       = 1'b1;
						emit.byte_valid = 1'b1;
					end
				end else begin
					st_n    = bdb_pkg::ST_OK;
					state_n = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit.load   = 1'b1;
					emit.status = st_q;
					emit.done   = 1'b1;
					inside_n    = 1'b0;
					discard_n   = !stat.last;
					state_n     = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			inside_q  <= 1'b0;
			discard_q <= 1'b0;
			st_q      <= bdb_pkg::ST_OK;
		end else begin
			state_q   <= state_n;
			inside_q  <= inside_n;
			discard_q <= discard_n;
			st_q      <= st_n;
		end
	end

	`ASSERT_IMPLY(a_no_overwrite, clk, arst_n, emit.load, out_free)
	`ASSERT_IMPLY(a_byte_in_buffer, clk, arst_n, emit.load && emit.byte_valid, stat.room)
	`ASSERT_NEXT(a_fin_to_idle, clk, arst_n, state_q == S_FIN && out_free, state_q == S_IDLE)
	`ASSERT_NEXT(a_discard_ends, clk, arst_n, accept && discard_q && last_digit,
		!discard_q && !inside_q)

endmodule

>>> bench/tb_bignum_digits_to_bytes_core.sv
// Self-checking bench for the big-integer digits-to-bytes converter core.
`timescale 1ns / 100ps

module tb_bignum_digits_to_bytes_core;

	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int SETTLE_CYCLES = 60;
	localparam int DRAIN_LIMIT   = 20_000;
	localparam int RANDOM_ITEMS  = 480;
	localparam logic [bdb_pkg::DIGIT_BITS-1:0] DIGIT_MAX = '1;

	typedef struct packed {
		logic [7:0]                byte_value;
		logic [bdb_pkg::POS_W-1:0] byte_position;
		logic                      byte_valid;
		logic [bdb_pkg::ST_W-1:0]  status;
		logic                      conversion_done;
	} out_rec_t;

	typedef enum logic {ROW_DIGIT, ROW_CONFIG} row_kind_t;

	typedef struct packed {
		row_kind_t                      kind;
		logic [1:0]                     reg_idx;
		logic [bdb_pkg::CNT_W-1:0]      reg_val;
		logic [bdb_pkg::DIGIT_BITS-1:0] digit;
		logic                           neg;
		logic                           last;
		logic                           typed;
		logic [bdb_pkg::ST_W-1:0]       want;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [bdb_pkg::ADDR_W-1:0]     paddr = '0;
	logic [bdb_pkg::DATA_W-1:0]     pwdata = '0;
	logic [bdb_pkg::DATA_W-1:0]     prdata;
	logic                           pready;
	logic                           item_valid = 1'b0;
	logic                           item_stall;
	logic [bdb_pkg::DIGIT_BITS-1:0] digit_value = '0;
	logic                           is_negative = 1'b0;
	logic                           last_digit = 1'b0;
	logic                           result_valid;
	logic                           result_stall = 1'b0;
	logic [7:0]                     byte_value;
	logic [bdb_pkg::POS_W-1:0]      byte_position;
	logic                           byte_valid;
	logic [bdb_pkg::ST_W-1:0]       status;
	logic                           conversion_done;

	bignum_digits_to_bytes_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall),
		.digit_value(digit_value), .is_negative(is_negative), .last_digit(last_digit),
		.result_valid(result_valid), .result_stall(result_stall),
		.byte_value(byte_value), .byte_position(byte_position), .byte_valid(byte_valid),
		.status(status), .conversion_done(conversion_done)
	);

	always #5 clk = ~clk;

	// converter copy: configuration and number state
	logic [bdb_pkg::CNT_W-1:0] cfg_count  = 6'd8;
	logic                      cfg_le     = 1'b1;
	logic                      cfg_signed = 1'b1;
	logic [bdb_pkg::ACC_W-1:0] pending_value = '0;
	int                        pending_bits  = 0;
	logic                      borrow_carry  = 1'b0;
	int                        bytes_out     = 0;
	logic                      top_bit       = 1'b0;
	logic                      in_number     = 1'b0;
	logic                      skipping      = 1'b0;

	out_rec_t awaited_outputs[$];
	int       error_count = 0;
	int       cycle_count = 0;
	bit       calm = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic int significant_bits(input logic [bdb_pkg::DIGIT_BITS-1:0] v);
		int len;
		len = 0;
		for (int i = 0; i < bdb_pkg::DIGIT_BITS; i++) begin
			if (v[i]) len = i + 1;
		end
		return len;
	endfunction

	function automatic void push_byte(input logic [7:0] val, input int n);
		out_rec_t r;
		r.byte_value      = val;
		r.byte_position   = bdb_pkg::POS_W'(cfg_le ? bytes_out : n - 1 - bytes_out);
		r.byte_valid      = 1'b1;
		r.status          = bdb_pkg::ST_OK;
		r.conversion_done = 1'b0;
		awaited_outputs.push_back(r);
		top_bit = val[7];
		bytes_out++;
	endfunction

	function automatic void close_number(input logic [bdb_pkg::ST_W-1:0] st, input logic last);
		out_rec_t r;
		r = '0;
		r.status          = st;
		r.conversion_done = 1'b1;
		awaited_outputs.push_back(r);
		in_number = 1'b0;
		skipping  = !last;
	endfunction

	// works out every result one accepted digit causes
	function automatic void convert_digit(input logic [bdb_pkg::DIGIT_BITS-1:0] d,
			input logic neg, input logic last);
		int                             n;
		logic [bdb_pkg::DIGIT_BITS:0]   sum;
		logic [bdb_pkg::DIGIT_BITS-1:0] t;
		logic                           neg_eff;
		logic [bdb_pkg::ACC_W-1:0]      b;
		n = (cfg_count > bdb_pkg::MAX_BYTES) ? bdb_pkg::MAX_BYTES : int'(cfg_count);
		if (skipping) begin
			if (last) begin
				skipping  = 1'b0;
				in_number = 1'b0;
			end
			return;
		end
		if (!in_number) begin
			pending_value = '0;
			pending_bits  = 0;
			borrow_carry  = neg;
			bytes_out     = 0;
			top_bit       = 1'b0;
			in_number     = 1'b1;
		end
		if (neg && !cfg_signed) begin
			close_number(bdb_pkg::ST_NEG_UNSIGNED, last);
			return;
		end
		if (neg) begin
			sum = {1'b0, ~d} + (bdb_pkg::DIGIT_BITS+1)'(borrow_carry);
			borrow_carry = sum[bdb_pkg::DIGIT_BITS];
			t = sum[bdb_pkg::DIGIT_BITS-1:0];
		end else begin
			t = d;
		end
		neg_eff = neg && !(last && borrow_carry);
		pending_value = pending_value | (bdb_pkg::ACC_W'(t) << pending_bits);
		if (last) pending_bits += significant_bits(neg_eff ? ~t : t);
		else pending_bits += bdb_pkg::DIGIT_BITS;
		while (pending_bits >= 8) begin
			if (bytes_out >= n) begin
				close_number(bdb_pkg::ST_TOO_BIG, last);
				return;
			end
			push_byte(pending_value[7:0], n);
			pending_bits -= 8;
			pending_value = pending_value >> 8;
		end
		if (!last) return;
		if (pending_bits > 0) begin
			b = pending_value;
			if (bytes_out >= n) begin
				close_number(bdb_pkg::ST_TOO_BIG, last);
				return;
			end
			// straggler byte padded with sign bits
			if (neg_eff) b = b | (bdb_pkg::ACC_W'(8'hff) << pending_bits);
			push_byte(b[7:0], n);
		end else if (bytes_out == n && n > 0 && cfg_signed) begin
			close_number((top_bit != neg_eff) ? bdb_pkg::ST_TOO_BIG : bdb_pkg::ST_OK, last);
			return;
		end
		while (bytes_out < n) push_byte(neg_eff ? 8'hff : 8'h00, n);
		close_number(bdb_pkg::ST_OK, last);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [bdb_pkg::DIGIT_BITS-1:0] pick_digit(input logic top);
		logic [bdb_pkg::DIGIT_BITS-1:0] v;
		int                             r;
		r = $urandom_range(0, 9);
		v = bdb_pkg::DIGIT_BITS'($urandom());
		if (r == 0) v = '0;
		else if (r == 1) v = DIGIT_MAX;
		else if (top && r < 6) v = v >> $urandom_range(0, bdb_pkg::DIGIT_BITS - 1);
		return v;
	endfunction

	function automatic stim_row_t dig_row(input logic [bdb_pkg::DIGIT_BITS-1:0] d,
			input logic neg, input logic last, input logic typed,
			input logic [bdb_pkg::ST_W-1:0] want);
		stim_row_t r;
		r = '0;
		r.kind  = ROW_DIGIT;
		r.digit = d;
		r.neg   = neg;
		r.last  = last;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(input logic [1:0] idx,
			input logic [bdb_pkg::CNT_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind    = ROW_CONFIG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	task automatic send_digit(input logic [bdb_pkg::DIGIT_BITS-1:0] d, input logic neg,
			input logic last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid  <= 1'b1;
		digit_value <= d;
		is_negative <= neg;
		last_digit  <= last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		convert_digit(d, neg, last);
	endtask

	// drop valid and let every awaited transaction come out
	task automatic wait_for_quiet();
		int waited;
		waited = 0;
		@(negedge clk);
		item_valid <= 1'b0;
		while (awaited_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [bdb_pkg::CNT_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= bdb_pkg::ADDR_W'({idx, 2'b00});
		pwdata  <= bdb_pkg::DATA_W'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			bdb_pkg::REG_BYTE_COUNT:  cfg_count = val;
			bdb_pkg::REG_LSB_FIRST:   cfg_le = val[0];
			bdb_pkg::REG_SIGNED_MODE: cfg_signed = val[0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_output();
		out_rec_t want;
		if (awaited_outputs.size() == 0) begin
			report_mismatch("transaction with nothing awaited", byte_value, -1);
			return;
		end
		want = awaited_outputs.pop_front();
		if (byte_value !== want.byte_value)
			report_mismatch("byte_value", byte_value, want.byte_value);
		if (byte_position !== want.byte_position)
			report_mismatch("byte_position", byte_position, want.byte_position);
		if (byte_valid !== want.byte_valid)
			report_mismatch("byte_valid", byte_valid, want.byte_valid);
		if (status !== want.status)
			report_mismatch("status", status, want.status);
		if (conversion_done !== want.conversion_done)
			report_mismatch("conversion_done", conversion_done, want.conversion_done);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) check_output();
	end

	// receiver back-pressure: runs of stall and go
	int stall_run = 0;
	always @(negedge clk) begin
		int g;
		if (stall_run > 0) begin
			stall_run--;
		end else if (result_stall) begin
			result_stall <= 1'b0;
			stall_run = $urandom_range(0, 5);
		end else begin
			g = pick_gap();
			if (g > 0) begin
				result_stall <= 1'b1;
				stall_run = g - 1;
			end else begin
				stall_run = $urandom_range(0, 3);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		stim_row_t                 directed_rows[$];
		stim_row_t                 row;
		out_rec_t                  tail;
		int                        random_sent;
		int                        phase;
		int                        ndig;
		int                        cap;
		int                        n;
		int                        r;
		logic                      neg;
		logic                      lastf;
		logic                      noise;
		logic [bdb_pkg::CNT_W-1:0] cnt;

		directed_rows = '{
			dig_row('0, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_OK),
			dig_row('0, 1'b1, 1'b1, 1'b1, bdb_pkg::ST_OK),          // negative zero
			dig_row(DIGIT_MAX, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_OK),
			dig_row(30'd1, 1'b1, 1'b1, 1'b1, bdb_pkg::ST_OK),       // minus one
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row('0, 1'b0, 1'b1, 1'b0, bdb_pkg::ST_OK),          // zero top digit
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(DIGIT_MAX, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_TOO_BIG),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b1, bdb_pkg::ST_TOO_BIG),
			dig_row(30'd5, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),       // swallowed after the overflow
			dig_row(30'd7, 1'b1, 1'b1, 1'b0, bdb_pkg::ST_OK),
			cfg_row(bdb_pkg::REG_BYTE_COUNT, 6'd4),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(30'd3, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_TOO_BIG),  // full buffer, top bit set
			cfg_row(bdb_pkg::REG_SIGNED_MODE, 6'd0),
			dig_row(DIGIT_MAX, 1'b0, 1'b0, 1'b0, bdb_pkg::ST_OK),
			dig_row(30'd3, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_OK),
			dig_row(30'd5, 1'b1, 1'b1, 1'b1, bdb_pkg::ST_NEG_UNSIGNED),
			dig_row(30'd5, 1'b1, 1'b0, 1'b1, bdb_pkg::ST_NEG_UNSIGNED),
			dig_row(30'd9, 1'b0, 1'b1, 1'b0, bdb_pkg::ST_OK),
			cfg_row(bdb_pkg::REG_SIGNED_MODE, 6'd1),
			cfg_row(bdb_pkg::REG_LSB_FIRST, 6'd0),
			cfg_row(bdb_pkg::REG_BYTE_COUNT, 6'd32),
			dig_row(30'h12345678, 1'b1, 1'b1, 1'b0, bdb_pkg::ST_OK),
			cfg_row(bdb_pkg::REG_BYTE_COUNT, 6'd0),
			dig_row('0, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_OK),
			dig_row(30'd1, 1'b0, 1'b1, 1'b1, bdb_pkg::ST_TOO_BIG),
			cfg_row(bdb_pkg::REG_BYTE_COUNT, 6'd63),                 // clamps to the maximum
			cfg_row(bdb_pkg::REG_LSB_FIRST, 6'd1),
			dig_row(30'h80, 1'b0, 1'b1, 1'b0, bdb_pkg::ST_OK),
			dig_row(30'd1, 1'b1, 1'b0, 1'b0, bdb_pkg::ST_OK),        // sign flips mid-number
			dig_row(30'd2, 1'b0, 1'b1, 1'b0, bdb_pkg::ST_OK)
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CONFIG) begin
				wait_for_quiet();
				write_register(row.reg_idx, row.reg_val);
			end else begin
				send_digit(row.digit, row.neg, row.last);
				if (row.typed && awaited_outputs.size() != 0) begin
					tail = awaited_outputs[awaited_outputs.size() - 1];
					if (tail.conversion_done) begin
						tail.status = row.want;
						awaited_outputs[awaited_outputs.size() - 1] = tail;
					end
				end
			end
		end

		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			wait_for_quiet();
			calm = (phase % 3 == 1);
			r = $urandom_range(0, 99);
			if (r < 40) cnt = bdb_pkg::CNT_W'($urandom_range(1, 8));
			else if (r < 60) cnt = bdb_pkg::CNT_W'($urandom_range(0, 16));
			else if (r < 75) cnt = 6'd32;
			else if (r < 85) cnt = 6'd0;
			else cnt = bdb_pkg::CNT_W'($urandom_range(33, 63));
			write_register(bdb_pkg::REG_BYTE_COUNT, cnt);
			write_register(bdb_pkg::REG_LSB_FIRST, bdb_pkg::CNT_W'($urandom_range(0, 1)));
			write_register(bdb_pkg::REG_SIGNED_MODE,
				bdb_pkg::CNT_W'(($urandom_range(0, 3) != 0) ? 1 : 0));
			n = (cfg_count > bdb_pkg::MAX_BYTES) ? bdb_pkg::MAX_BYTES : int'(cfg_count);
			cap = n * 8 / bdb_pkg::DIGIT_BITS + 2;
			for (int k = 0; k < 60 && random_sent < RANDOM_ITEMS; ) begin
				ndig  = $urandom_range(1, cap);
				neg   = $urandom_range(0, 99) < (cfg_signed ? 45 : 15);
				noise = $urandom_range(0, 99) < 10;
				for (int j = 0; j < ndig; j++) begin
					lastf = (j == ndig - 1);
					// broken sequences: stray marks and mixed signs
					if (noise) begin
						lastf = ($urandom_range(0, 3) == 0);
						neg = 1'($urandom_range(0, 1));
					end
					send_digit(pick_digit(lastf), neg, lastf);
					random_sent++;
					k++;
				end
				if ($urandom_range(0, 19) == 0) wait_for_quiet();
			end
			phase++;
		end

		wait_for_quiet();
		while (awaited_outputs.size() != 0) begin
			tail = awaited_outputs.pop_front();
			report_mismatch("transaction never delivered", -1, tail.byte_value);
		end
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
